// ===== rtl/core/blm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants of the battery level monitor
// Filter steps, voltage scale, level codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Sample width default
  localparam int SAMPLE_BITS_DEF = 12;

  // Slew filter steps and gaps
  localparam int BIG_STEP_GAP   = 20;
  localparam int BIG_STEP       = 10;
  localparam int SMALL_STEP_GAP = 5;
  localparam int SMALL_STEP     = 2;
  localparam int FILTER_RESET   = 1400;

  // Voltage scale: full-scale reading maps to 16.5 V in tenths
  localparam int VOLT_BITS  = 8;
  localparam int VOLT_SCALE = 33 * 5;

  // Level and counter widths
  localparam int LEVEL_BITS = 3;
  localparam int TRIP_BITS  = 4;

  // Charge level codes
  localparam logic [LEVEL_BITS-1:0] LEVEL_0 = 3'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_1 = 3'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_2 = 3'd2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_3 = 3'd3;
  localparam logic [LEVEL_BITS-1:0] LEVEL_4 = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL4_ABOVE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL3_ABOVE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL2_ABOVE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL1_MIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP_LIMIT   = 3'd4;

  // Configuration reset values
  localparam logic [VOLT_BITS-1:0] LEVEL4_ABOVE_RST = 8'd55;
  localparam logic [VOLT_BITS-1:0] LEVEL3_ABOVE_RST = 8'd51;
  localparam logic [VOLT_BITS-1:0] LEVEL2_ABOVE_RST = 8'd46;
  localparam logic [VOLT_BITS-1:0] LEVEL1_MIN_RST   = 8'd43;
  localparam logic [TRIP_BITS-1:0] TRIP_LIMIT_RST   = 4'd3;

  // Threshold set seen by the classifier
  typedef struct packed {
    logic [VOLT_BITS-1:0] level4_above;
    logic [VOLT_BITS-1:0] level3_above;
    logic [VOLT_BITS-1:0] level2_above;
    logic [VOLT_BITS-1:0] level1_min;
    logic [TRIP_BITS-1:0] trip_limit;
  } cfg_regs_t;

endpackage

// ===== rtl/core/blm_slew.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_slew: slew-limited filter stage
// Moves the filter value toward each accepted sample by a big or small step.
// The filter register doubles as the first pipeline stage payload.
// ----------------------------------------------------------------------------
module blm_slew #(
  parameter int SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   valid,
  output logic [SAMPLE_BITS-1:0] filter
);
  import blm_pkg::*;

  localparam int WB = SAMPLE_BITS + 1;

  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] filter_r;
  logic [SAMPLE_BITS-1:0] filter_nxt;
  logic [WB-1:0]          cur_w;
  logic [WB-1:0]          tgt_w;

  assign cur_w = {1'b0, filter_r};
  assign tgt_w = {1'b0, sample};

  // Step toward the sample; the step never passes it, so no wrap
  always_comb begin
    filter_nxt = filter_r;
    if (tgt_w > cur_w) begin
      if (tgt_w > cur_w + WB'(BIG_STEP_GAP)) begin
        filter_nxt = filter_r + SAMPLE_BITS'(BIG_STEP);
      end else if (tgt_w > cur_w + WB'(SMALL_STEP_GAP)) begin
        filter_nxt = filter_r + SAMPLE_BITS'(SMALL_STEP);
      end
    end else if (cur_w > tgt_w) begin
      if (cur_w > tgt_w + WB'(BIG_STEP_GAP)) begin
        filter_nxt = filter_r - SAMPLE_BITS'(BIG_STEP);
      end else if (cur_w > tgt_w + WB'(SMALL_STEP_GAP)) begin
        filter_nxt = filter_r - SAMPLE_BITS'(SMALL_STEP);
      end
    end
  end

  // Update filter state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      filter_r <= SAMPLE_BITS'(FILTER_RESET);
    end else if (adv) begin
      valid_r <= accept;
      if (accept) begin
        filter_r <= filter_nxt;
      end
    end
  end

  assign valid  = valid_r;
  assign filter = filter_r;

endmodule

// ===== rtl/core/blm_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_scale: voltage scaling stage
// Multiplies the filter value by the full-scale factor and keeps the top bits
// as battery voltage in tenths of a volt.
// ----------------------------------------------------------------------------
module blm_scale #(
  parameter int SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [SAMPLE_BITS-1:0]        filter_in,
  output logic                          valid,
  output logic [SAMPLE_BITS-1:0]        filter_out,
  output logic [blm_pkg::VOLT_BITS-1:0] volts
);
  import blm_pkg::*;

  localparam int PW = SAMPLE_BITS + VOLT_BITS;

  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] filter_r;
  logic [VOLT_BITS-1:0]   volts_r;
  logic [PW-1:0]          prod;

  // Scale: filter * 165 / 2^SAMPLE_BITS, always below 165
  assign prod = PW'(filter_in) * PW'(VOLT_SCALE);

  // Hold valid under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  // Capture scaled voltage and pass filter value along
  always_ff @(posedge clk) begin
    if (adv) begin
      filter_r <= filter_in;
      volts_r  <= prod[PW-1:SAMPLE_BITS];
    end
  end

  assign valid      = valid_r;
  assign filter_out = filter_r;
  assign volts      = volts_r;

endmodule

// ===== rtl/core/blm_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_level: level classifier, trip counter and result register
// Classifies the voltage by the thresholds, runs the low-level trip counter
// and protection flag, and holds the result request.
// ----------------------------------------------------------------------------
module blm_level #(
  parameter int SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  blm_pkg::cfg_regs_t             cfg,
  input  logic                           in_valid,
  input  logic [SAMPLE_BITS-1:0]         filter_in,
  input  logic [blm_pkg::VOLT_BITS-1:0]  volts_in,
  output logic                           out_valid,
  output logic [SAMPLE_BITS-1:0]         filter_out,
  output logic [blm_pkg::VOLT_BITS-1:0]  volts_out,
  output logic [blm_pkg::LEVEL_BITS-1:0] level_out,
  output logic                           protect_out
);
  import blm_pkg::*;

  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] filter_r;
  logic [VOLT_BITS-1:0]   volts_r;
  logic [LEVEL_BITS-1:0]  level_r;
  logic [TRIP_BITS-1:0]   trip_r;
  logic [TRIP_BITS-1:0]   trip_nxt;
  logic                   protect_r;
  logic                   protect_nxt;
  logic [LEVEL_BITS-1:0]  level;

  // Classify from the top level down; first match wins
  always_comb begin
    priority if (volts_in > cfg.level4_above) begin
      level = LEVEL_4;
    end else if (volts_in > cfg.level3_above) begin
      level = LEVEL_3;
    end else if (volts_in > cfg.level2_above) begin
      level = LEVEL_2;
    end else if (volts_in >= cfg.level1_min) begin
      level = LEVEL_1;
    end else begin
      level = LEVEL_0;
    end
  end

  // Count up at the lowest level, down otherwise; set or clear flag at the ends
  always_comb begin
    trip_nxt    = trip_r;
    protect_nxt = protect_r;
    if (level == LEVEL_0) begin
      if (trip_r < cfg.trip_limit) begin
        trip_nxt = trip_r + TRIP_BITS'(1);
      end else begin
        protect_nxt = 1'b1;
      end
    end else begin
      if (trip_r != '0) begin
        trip_nxt = trip_r - TRIP_BITS'(1);
      end else begin
        protect_nxt = 1'b0;
      end
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      trip_r    <= '0;
      protect_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
      if (in_valid) begin
        trip_r    <= trip_nxt;
        protect_r <= protect_nxt;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      filter_r <= filter_in;
      volts_r  <= volts_in;
      level_r  <= level;
    end
  end

  assign out_valid   = valid_r;
  assign filter_out  = filter_r;
  assign volts_out   = volts_r;
  assign level_out   = level_r;
  assign protect_out = protect_r;

endmodule

// ===== rtl/core/battery_level_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor: battery ADC filter, level classifier and trip guard
// Slew-limits the ADC samples, scales to tenths of a volt, classifies the
// level and drives low-battery protection.
// ----------------------------------------------------------------------------
// The block takes one ADC sample per clock while in_tready is high and
// returns one result per accepted sample, in order. The three stages are
// the slew filter (its state loop closes within the stage), the multiply that
// scales the filter value to tenths of a volt, and the classifier with the
// trip counter (its loop also closes within the stage). in_tready falls only
// while a result sits in the output register and out_tready is low. There is
// no clearing pass after reset. Threshold and trip-limit writes are taken at
// any time and should be made while no sample is in flight.
module battery_level_monitor #(
  parameter int SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + blm_pkg::VOLT_BITS + blm_pkg::LEVEL_BITS + 1 + 7)
                          / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: adc_sample
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,
  // out_tdata: filtered_sample, voltage_tenths, charge_level, low_protect
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [blm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import blm_pkg::*;

  cfg_regs_t              cfg_r;
  logic                   adv;
  logic                   accept;
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_filter;
  logic                   s2_valid;
  logic [SAMPLE_BITS-1:0] s2_filter;
  logic [VOLT_BITS-1:0]   s2_volts;
  logic [SAMPLE_BITS-1:0] res_filter;
  logic [VOLT_BITS-1:0]   res_volts;
  logic [LEVEL_BITS-1:0]  res_level;
  logic                   res_protect;

  // Advance the pipeline unless a result is stalled at the output
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level4_above <= LEVEL4_ABOVE_RST;
      cfg_r.level3_above <= LEVEL3_ABOVE_RST;
      cfg_r.level2_above <= LEVEL2_ABOVE_RST;
      cfg_r.level1_min   <= LEVEL1_MIN_RST;
      cfg_r.trip_limit   <= TRIP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEVEL4_ABOVE: cfg_r.level4_above <= cfg_data;
        CFG_LEVEL3_ABOVE: cfg_r.level3_above <= cfg_data;
        CFG_LEVEL2_ABOVE: cfg_r.level2_above <= cfg_data;
        CFG_LEVEL1_MIN:   cfg_r.level1_min   <= cfg_data;
        CFG_TRIP_LIMIT:   cfg_r.trip_limit   <= cfg_data[TRIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  blm_slew #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_slew (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .accept (accept),
    .sample (in_tdata[SAMPLE_BITS-1:0]),
    .valid  (s1_valid),
    .filter (s1_filter)
  );

  blm_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (s1_valid),
    .filter_in  (s1_filter),
    .valid      (s2_valid),
    .filter_out (s2_filter),
    .volts      (s2_volts)
  );

  blm_level #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .cfg         (cfg_r),
    .in_valid    (s2_valid),
    .filter_in   (s2_filter),
    .volts_in    (s2_volts),
    .out_valid   (out_tvalid),
    .filter_out  (res_filter),
    .volts_out   (res_volts),
    .level_out   (res_level),
    .protect_out (res_protect)
  );

  // Pack result fields from the lowest bit up, zero-filled to whole bytes
  assign out_tdata = OUT_W'({res_protect, res_level, res_volts, res_filter});

endmodule
